[hw/rtl/ellipse_point_classify_defines.svh]
// Assertion helpers for the checker file.
`ifndef ELLIPSE_POINT_CLASSIFY_DEFINES_SVH
`define ELLIPSE_POINT_CLASSIFY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define EPC_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define EPC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/epc_pkg.sv]
package epc_pkg;

    localparam int VEL_W      = 16;
    localparam int PT_W       = 20;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_W     = 12;

    localparam int VSQ_W      = 2 * VEL_W;
    localparam int SPEED_W    = 16;
    localparam int SQRT_STEPS = SPEED_W;
    localparam int XSQ_W      = 2 * PT_W - 1;
    localparam int A_W        = 20;
    localparam int BS_W       = 31;
    localparam int BMAG_W     = 29;
    localparam int ASQ_W      = 2 * A_W;
    localparam int BSQ_W      = 2 * BMAG_W;

    localparam int DIV_NUM_W  = 56;
    localparam int DIV_DEN_W  = 58;
    localparam int DIV_Q_W    = 28;
    localparam int COND_W     = 31;

    localparam logic [CFG_W-1:0] V0_FLOOR_CODE = 16'd4;
    localparam logic [CFG_W-1:0] RST_A_MIN     = 16'd737;
    localparam logic [CFG_W-1:0] RST_A_PER_SPD = 16'd2171;
    localparam logic [CFG_W-1:0] RST_B_MIN     = 16'd819;
    localparam logic [CFG_W-1:0] RST_B_MAX     = 16'd1024;
    localparam logic [CFG_W-1:0] RST_V0        = 16'd0;
    localparam logic             RST_STRETCH   = 1'b1;
    localparam logic [CFG_W-1:0] RST_TOL       = 16'd66;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_A_MIN,
        REG_A_PER_SPEED,
        REG_B_MIN,
        REG_B_MAX,
        REG_DESIRED_SPEED,
        REG_STRETCH,
        REG_TOLERANCE
    } cfg_reg_t;

    typedef enum logic [1:0] {
        BMODE_MAX,
        BMODE_MIN,
        BMODE_SCALE
    } bmode_t;

    // Per-item data that rides alongside the arithmetic units.
    typedef struct packed {
        logic [XSQ_W-1:0] xsq;
        logic [XSQ_W-1:0] ysq;
        logic [A_W-1:0]   a;
        logic             bneg;
        bmode_t           bmode;
        logic             deg;
        logic             ty_zero;
    } epc_side_t;

endpackage

[hw/rtl/ellipse_point_classify.sv]
// The block takes one word per cycle while the output is not held; a fully occupied pipeline
// accepts a new word every cycle as long as its results are taken.
// The whole pipeline advances together; it holds when a result waits, and a one-word
// input skid buffer still takes one more word during such a hold.
// Reset (aresetn low, synchronous) clears all valid bits and the skid buffer and loads
// the configuration registers with their default values.
module ellipse_point_classify
    import epc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [CFG_IDX_W-1:0]        cfg_addr,
    input  logic [CFG_W-1:0]            cfg_wdata,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic signed [VEL_W-1:0]     s_vel_x,
    input  logic signed [VEL_W-1:0]     s_vel_y,
    input  logic signed [PT_W-1:0]      s_point_x,
    input  logic signed [PT_W-1:0]      s_point_y,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_inside_res,
    output logic                        m_outside,
    output logic                        m_on_boundary,
    output logic                        m_degenerate
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always accepted; the block is
    // expected to be idle while they change, so every stage reads them
    // directly.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] amin_reg;
    logic [CFG_W-1:0] av_reg;
    logic [CFG_W-1:0] bmin_reg;
    logic [CFG_W-1:0] bmax_reg;
    logic [CFG_W-1:0] v0_reg;
    logic             stretch_reg;
    logic [CFG_W-1:0] tol_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            amin_reg    <= RST_A_MIN;
            av_reg      <= RST_A_PER_SPD;
            bmin_reg    <= RST_B_MIN;
            bmax_reg    <= RST_B_MAX;
            v0_reg      <= RST_V0;
            stretch_reg <= RST_STRETCH;
            tol_reg     <= RST_TOL;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_reg_t'(cfg_addr))
                REG_A_MIN:         amin_reg    <= cfg_wdata;
                REG_A_PER_SPEED:   av_reg      <= cfg_wdata;
                REG_B_MIN:         bmin_reg    <= cfg_wdata;
                REG_B_MAX:         bmax_reg    <= cfg_wdata;
                REG_DESIRED_SPEED: v0_reg      <= cfg_wdata;
                REG_STRETCH:       stretch_reg <= cfg_wdata[0];
                REG_TOLERANCE:     tol_reg     <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Global pipeline enable. Every stage moves when the output register
    // is empty or its word is being taken.
    // ------------------------------------------------------------------
    logic pipe_en;
    logic out_valid_reg;

    assign pipe_en = m_ready || !out_valid_reg;

    // ------------------------------------------------------------------
    // Input skid buffer. It catches one word that arrives while the
    // pipeline holds; s_ready drops only while it is full.
    // ------------------------------------------------------------------
    logic                    skid_valid_reg;
    logic                    skid_valid_next;
    logic signed [VEL_W-1:0] skid_vx_reg;
    logic signed [VEL_W-1:0] skid_vy_reg;
    logic signed [PT_W-1:0]  skid_px_reg;
    logic signed [PT_W-1:0]  skid_py_reg;

    assign s_ready = !skid_valid_reg;

    always_comb begin
        skid_valid_next = skid_valid_reg;
        if (pipe_en) begin
            skid_valid_next = 1'b0;
        end else if (s_valid && s_ready) begin
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!pipe_en && s_valid && s_ready) begin
            skid_vx_reg <= s_vel_x;
            skid_vy_reg <= s_vel_y;
            skid_px_reg <= s_point_x;
            skid_py_reg <= s_point_y;
        end
    end

    // The pipeline takes the skid word first, otherwise the port word.
    logic                    in_v;
    logic signed [VEL_W-1:0] in_vx;
    logic signed [VEL_W-1:0] in_vy;
    logic signed [PT_W-1:0]  in_px;
    logic signed [PT_W-1:0]  in_py;

    assign in_v  = skid_valid_reg || s_valid;
    assign in_vx = skid_valid_reg ? skid_vx_reg : s_vel_x;
    assign in_vy = skid_valid_reg ? skid_vy_reg : s_vel_y;
    assign in_px = skid_valid_reg ? skid_px_reg : s_point_x;
    assign in_py = skid_valid_reg ? skid_py_reg : s_point_y;

    // ------------------------------------------------------------------
    // Stage 0: squares of the velocity components and of the point.
    // ------------------------------------------------------------------
    logic signed [2*VEL_W-1:0] vxx;
    logic signed [2*VEL_W-1:0] vyy;
    logic signed [2*PT_W-1:0]  pxx;
    logic signed [2*PT_W-1:0]  pyy;
    epc_side_t                 s0_side_next;

    logic             s0_valid_reg;
    logic [VSQ_W-1:0] s0_vsq_reg;
    epc_side_t        s0_side_reg;

    assign vxx = in_vx * in_vx;
    assign vyy = in_vy * in_vy;
    assign pxx = in_px * in_px;
    assign pyy = in_py * in_py;

    always_comb begin
        s0_side_next         = '0;
        s0_side_next.xsq     = pxx[XSQ_W-1:0];
        s0_side_next.ysq     = pyy[XSQ_W-1:0];
        s0_side_next.bmode   = BMODE_MAX;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s0_valid_reg <= in_v;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            s0_vsq_reg  <= unsigned'(vxx) + unsigned'(vyy);
            s0_side_reg <= s0_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Speed: pipelined integer square root, one bit per stage.
    // ------------------------------------------------------------------
    logic               sq_valid;
    logic [SPEED_W-1:0] sq_root;
    epc_side_t          sq_side;

    epc_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s0_valid_reg),
        .in_vsq    (s0_vsq_reg),
        .in_side   (s0_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // ------------------------------------------------------------------
    // Stage A: forward semi-axis, and the numerator of the shoulder
    // shrink term speed * |bmax - bmin|.
    // ------------------------------------------------------------------
    logic [2*CFG_W-1:0]  prod_a;
    logic signed [CFG_W:0] bdiff;
    logic [CFG_W-1:0]    bdiff_mag;
    logic [2*CFG_W-1:0]  shrink_num;
    epc_side_t           sa_side_next;

    logic               sa_valid_reg;
    logic [2*CFG_W-1:0] sa_num_reg;
    epc_side_t          sa_side_reg;

    always_comb begin
        prod_a     = sq_root * av_reg;
        bdiff      = $signed({1'b0, bmax_reg}) - $signed({1'b0, bmin_reg});
        bdiff_mag  = bdiff[CFG_W] ? CFG_W'(-bdiff) : bdiff[CFG_W-1:0];
        shrink_num = sq_root * bdiff_mag;

        sa_side_next      = sq_side;
        sa_side_next.a    = A_W'(amin_reg) + prod_a[2*CFG_W-1:FRAC_W];
        sa_side_next.bneg = bdiff[CFG_W];
        if (!stretch_reg) begin
            sa_side_next.bmode = BMODE_MIN;
        end else if (v0_reg <= V0_FLOOR_CODE) begin
            sa_side_next.bmode = BMODE_MAX;
        end else begin
            sa_side_next.bmode = BMODE_SCALE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sa_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            sa_valid_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sa_num_reg  <= shrink_num;
            sa_side_reg <= sa_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Shrink amount: numerator divided by the desired speed. A quotient
    // that overflows makes the shoulder axis so large that the y term is
    // zero.
    // ------------------------------------------------------------------
    logic               d1_valid;
    logic [DIV_Q_W-1:0] d1_quo;
    logic               d1_ovf;
    epc_side_t          d1_side;

    epc_div u_div_shrink (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (sa_valid_reg),
        .in_num    (DIV_NUM_W'(sa_num_reg)),
        .in_den    (DIV_DEN_W'(v0_reg)),
        .in_side   (sa_side_reg),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_ovf   (d1_ovf),
        .out_side  (d1_side)
    );

    // ------------------------------------------------------------------
    // Stage B: shoulder semi-axis, its magnitude and the zero-axis check.
    // ------------------------------------------------------------------
    logic signed [BS_W-1:0] bmax_s;
    logic signed [BS_W-1:0] bmin_s;
    logic signed [BS_W-1:0] delta_s;
    logic signed [BS_W-1:0] bval;
    logic [BS_W-1:0]        babs;
    epc_side_t              sb_side_next;

    logic              sb_valid_reg;
    logic [BMAG_W-1:0] sb_bmag_reg;
    epc_side_t         sb_side_reg;

    always_comb begin
        bmax_s  = $signed({{(BS_W-CFG_W){1'b0}}, bmax_reg});
        bmin_s  = $signed({{(BS_W-CFG_W){1'b0}}, bmin_reg});
        delta_s = $signed({{(BS_W-DIV_Q_W){1'b0}}, d1_quo});
        case (d1_side.bmode)
            BMODE_MIN:   bval = bmin_s;
            BMODE_SCALE: bval = d1_side.bneg ? (bmax_s + delta_s) : (bmax_s - delta_s);
            default:     bval = bmax_s;
        endcase
        babs = bval[BS_W-1] ? unsigned'(-bval) : unsigned'(bval);

        sb_side_next         = d1_side;
        sb_side_next.ty_zero = (d1_side.bmode == BMODE_SCALE) && d1_ovf;
        sb_side_next.deg     = (d1_side.a == '0) || (!sb_side_next.ty_zero && (bval == '0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sb_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            sb_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sb_bmag_reg <= babs[BMAG_W-1:0];
            sb_side_reg <= sb_side_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: squares of both semi-axes.
    // ------------------------------------------------------------------
    logic             sc_valid_reg;
    logic [ASQ_W-1:0] sc_asq_reg;
    logic [BSQ_W-1:0] sc_bsq_reg;
    epc_side_t        sc_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sc_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            sc_valid_reg <= sb_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sc_asq_reg  <= sb_side_reg.a * sb_side_reg.a;
            sc_bsq_reg  <= sb_bmag_reg * sb_bmag_reg;
            sc_side_reg <= sb_side_reg;
        end
    end

    // ------------------------------------------------------------------
    // Normalized terms x^2/a^2 and y^2/b^2 in Q.16, computed side by side.
    // ------------------------------------------------------------------
    logic               dx_valid;
    logic [DIV_Q_W-1:0] dx_quo;
    logic               dx_ovf;
    epc_side_t          dx_side;
    logic               dy_valid;
    logic [DIV_Q_W-1:0] dy_quo;
    logic               dy_ovf;
    epc_side_t          dy_side;

    epc_div u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (sc_valid_reg),
        .in_num    (DIV_NUM_W'({sc_side_reg.xsq, 16'h0000})),
        .in_den    (DIV_DEN_W'(sc_asq_reg)),
        .in_side   (sc_side_reg),
        .out_valid (dx_valid),
        .out_quo   (dx_quo),
        .out_ovf   (dx_ovf),
        .out_side  (dx_side)
    );

    epc_div u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (sc_valid_reg),
        .in_num    (DIV_NUM_W'({sc_side_reg.ysq, 16'h0000})),
        .in_den    (DIV_DEN_W'(sc_bsq_reg)),
        .in_side   (sc_side_reg),
        .out_valid (dy_valid),
        .out_quo   (dy_quo),
        .out_ovf   (dy_ovf),
        .out_side  (dy_side)
    );

    // ------------------------------------------------------------------
    // Final stage: condition c = tx + ty - 1.0 and the flags. An
    // overflowed term is clipped; it is far beyond any tolerance band, so
    // the flags come out the same as with the exact value.
    // ------------------------------------------------------------------
    logic [DIV_Q_W:0]         tx;
    logic [DIV_Q_W:0]         ty;
    logic [DIV_Q_W+1:0]       tsum;
    logic signed [COND_W-1:0] cond;
    logic signed [COND_W-1:0] tol_s;
    logic                     fin_valid;

    logic out_inside_reg;
    logic out_outside_reg;
    logic out_on_reg;
    logic out_deg_reg;

    always_comb begin
        tx    = dx_ovf ? {1'b1, {DIV_Q_W{1'b0}}} : {1'b0, dx_quo};
        if (dy_side.ty_zero) begin
            ty = '0;
        end else begin
            ty = dy_ovf ? {1'b1, {DIV_Q_W{1'b0}}} : {1'b0, dy_quo};
        end
        tsum      = (DIV_Q_W + 2)'(tx) + (DIV_Q_W + 2)'(ty);
        cond      = $signed(COND_W'(tsum)) - $signed(COND_W'(32'h0001_0000));
        tol_s     = $signed({{(COND_W-CFG_W){1'b0}}, tol_reg});
        fin_valid = dx_valid && dy_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= fin_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            out_deg_reg     <= dx_side.deg;
            out_inside_reg  <= !dx_side.deg && (cond < 0);
            out_outside_reg <= !dx_side.deg && (cond > 0);
            out_on_reg      <= !dx_side.deg && (cond > -tol_s) && (cond < tol_s);
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_inside_res  = out_inside_reg;
    assign m_outside     = out_outside_reg;
    assign m_on_boundary = out_on_reg;
    assign m_degenerate  = out_deg_reg;

endmodule

[hw/rtl/epc_sqrt.sv]
module epc_sqrt
    import epc_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [VSQ_W-1:0]   in_vsq,
    input  epc_side_t          in_side,
    output logic               out_valid,
    output logic [SPEED_W-1:0] out_root,
    output epc_side_t          out_side
);

    // One result bit per stage, classic digit-by-digit square root.
    logic [VSQ_W-1:0] n_reg    [SQRT_STEPS];
    logic [VSQ_W-1:0] res_reg  [SQRT_STEPS];
    logic             v_reg    [SQRT_STEPS];
    epc_side_t        side_reg [SQRT_STEPS];

    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_stage
        localparam logic [VSQ_W-1:0] BITVAL = VSQ_W'(1) << (2 * (SQRT_STEPS - 1 - i));
        logic [VSQ_W-1:0] n_in;
        logic [VSQ_W-1:0] res_in;
        logic             v_in;
        epc_side_t        side_in;
        logic [VSQ_W-1:0] sum;
        logic [VSQ_W-1:0] n_next;
        logic [VSQ_W-1:0] res_next;

        if (i == 0) begin : g_first
            assign n_in    = in_vsq;
            assign res_in  = '0;
            assign v_in    = in_valid;
            assign side_in = in_side;
        end else begin : g_rest
            assign n_in    = n_reg[i-1];
            assign res_in  = res_reg[i-1];
            assign v_in    = v_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        always_comb begin
            sum = res_in + BITVAL;
            if (n_in >= sum) begin
                n_next   = n_in - sum;
                res_next = (res_in >> 1) + BITVAL;
            end else begin
                n_next   = n_in;
                res_next = res_in >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (en) begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[i]    <= n_next;
                res_reg[i]  <= res_next;
                side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[SQRT_STEPS-1];
    assign out_root  = res_reg[SQRT_STEPS-1][SPEED_W-1:0];
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule

[hw/rtl/epc_div.sv]
module epc_div
    import epc_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [DIV_NUM_W-1:0] in_num,
    input  logic [DIV_DEN_W-1:0] in_den,
    input  epc_side_t            in_side,
    output logic                 out_valid,
    output logic [DIV_Q_W-1:0]   out_quo,
    output logic                 out_ovf,
    output epc_side_t            out_side
);

    // Restoring division, one quotient bit per stage, most significant first.
    // The overflow flag marks a quotient that does not fit the quotient width.
    localparam int CMP_W = DIV_DEN_W + DIV_Q_W;

    logic [DIV_NUM_W-1:0] rem_reg  [DIV_Q_W];
    logic [DIV_DEN_W-1:0] den_reg  [DIV_Q_W];
    logic [DIV_Q_W-1:0]   quo_reg  [DIV_Q_W];
    logic                 ovf_reg  [DIV_Q_W];
    logic                 v_reg    [DIV_Q_W];
    epc_side_t            side_reg [DIV_Q_W];

    for (genvar j = 0; j < DIV_Q_W; j++) begin : g_stage
        localparam int K = DIV_Q_W - 1 - j;
        logic [DIV_NUM_W-1:0] rem_in;
        logic [DIV_DEN_W-1:0] den_in;
        logic [DIV_Q_W-1:0]   quo_in;
        logic                 ovf_in;
        logic                 v_in;
        epc_side_t            side_in;
        logic [CMP_W-1:0]     trial;
        logic                 fits;
        logic [DIV_NUM_W-1:0] rem_next;
        logic [DIV_Q_W-1:0]   quo_next;

        if (j == 0) begin : g_first
            assign rem_in  = in_num;
            assign den_in  = in_den;
            assign quo_in  = '0;
            assign ovf_in  = CMP_W'(in_num) >= (CMP_W'(in_den) << DIV_Q_W);
            assign v_in    = in_valid;
            assign side_in = in_side;
        end else begin : g_rest
            assign rem_in  = rem_reg[j-1];
            assign den_in  = den_reg[j-1];
            assign quo_in  = quo_reg[j-1];
            assign ovf_in  = ovf_reg[j-1];
            assign v_in    = v_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        always_comb begin
            trial    = CMP_W'(den_in) << K;
            fits     = CMP_W'(rem_in) >= trial;
            rem_next = fits ? DIV_NUM_W'(CMP_W'(rem_in) - trial) : rem_in;
            quo_next = quo_in;
            quo_next[K] = fits;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]  <= rem_next;
                den_reg[j]  <= den_in;
                quo_reg[j]  <= quo_next;
                ovf_reg[j]  <= ovf_in;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[DIV_Q_W-1];
    assign out_quo   = quo_reg[DIV_Q_W-1];
    assign out_ovf   = ovf_reg[DIV_Q_W-1];
    assign out_side  = side_reg[DIV_Q_W-1];

endmodule

[hw/rtl/epc_checker.sv]
`include "ellipse_point_classify_defines.svh"

module epc_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_valid,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_inside_res,
    input logic m_outside,
    input logic m_on_boundary,
    input logic m_degenerate
);

    // A degenerate ellipse reports no position flag.
    `EPC_ASSERT_IMPL(a_deg_clears, aclk, aresetn, m_valid && m_degenerate, !m_inside_res && !m_outside && !m_on_boundary, "degenerate word carries position flags")

    // A point cannot be inside and outside at once.
    `EPC_ASSERT_IMPL(a_in_out_excl, aclk, aresetn, m_valid, !(m_inside_res && m_outside), "inside and outside both set")

    // The input side only backs up while a finished word waits.
    `EPC_ASSERT_IMPL(a_stall_cause, aclk, aresetn, !s_ready, m_valid, "input stalled with no result pending")

    // A waiting result stays put.
    `EPC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable({m_inside_res, m_outside, m_on_boundary, m_degenerate}), "result changed while stalled")

endmodule

bind ellipse_point_classify epc_checker u_epc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_inside_res  (m_inside_res),
    .m_outside     (m_outside),
    .m_on_boundary (m_on_boundary),
    .m_degenerate  (m_degenerate)
);

[tb/sv/testbench.sv]
module testbench;
    import epc_pkg::*;

    // Result flags of one classified point, in the order the m_ channel carries them.
    typedef struct packed {
        logic inside_res;
        logic outside;
        logic on_boundary;
        logic degenerate;
    } flags_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_addr;
    logic [CFG_W-1:0]         cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [VEL_W-1:0]  s_vel_x;
    logic signed [VEL_W-1:0]  s_vel_y;
    logic signed [PT_W-1:0]   s_point_x;
    logic signed [PT_W-1:0]   s_point_y;
    logic                     m_valid;
    logic                     m_ready;
    logic                     m_inside_res;
    logic                     m_outside;
    logic                     m_on_boundary;
    logic                     m_degenerate;

    ellipse_point_classify dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_vel_x       (s_vel_x),
        .s_vel_y       (s_vel_y),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_inside_res  (m_inside_res),
        .m_outside     (m_outside),
        .m_on_boundary (m_on_boundary),
        .m_degenerate  (m_degenerate)
    );

    // The testbench keeps its own copy of the configuration. It is updated from the
    // observed register writes, so it always matches what the block has latched.
    logic [CFG_W-1:0] shadow_a_min;
    logic [CFG_W-1:0] shadow_a_per_speed;
    logic [CFG_W-1:0] shadow_b_min;
    logic [CFG_W-1:0] shadow_b_max;
    logic [CFG_W-1:0] shadow_v0;
    logic             shadow_stretch;
    logic [CFG_W-1:0] shadow_tol;

    flags_t expected_flags[$];
    int     mismatch_count = 0;
    bit     sender_idle_on;
    bit     receiver_idle_on;
    int     hold_len;
    bit     hold_done;
    int     quiet_cycles;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 100;

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Integer square root, bit by bit, rounding down.
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned probe;
        root  = 0;
        probe = 64'd1 << 62;
        while (probe > n) probe = probe >> 2;
        while (probe != 0) begin
            if (n >= root + probe) begin
                n    = n - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    function automatic longint unsigned speed_of(input logic signed [VEL_W-1:0] vx,
                                                 input logic signed [VEL_W-1:0] vy);
        longint sx;
        longint sy;
        sx = vx;
        sy = vy;
        return int_sqrt(longint'(sx * sx + sy * sy));
    endfunction

    // Forward semi-axis grows linearly with speed.
    function automatic longint unsigned forward_axis(input longint unsigned spd);
        return longint'(shadow_a_min) + ((spd * longint'(shadow_a_per_speed)) >> FRAC_W);
    endfunction

    // Shoulder semi-axis; it may come out negative when it shrinks past zero.
    function automatic longint shoulder_axis(input longint unsigned spd);
        longint diff;
        longint delta;
        longint unsigned mag;
        if (!shadow_stretch) return longint'(shadow_b_min);
        if (shadow_v0 <= V0_FLOOR_CODE) return longint'(shadow_b_max);
        diff  = longint'(shadow_b_max) - longint'(shadow_b_min);
        mag   = (diff < 0) ? -diff : diff;
        delta = longint'((spd * mag) / longint'(shadow_v0));
        if (diff < 0) delta = -delta;
        return longint'(shadow_b_max) - delta;
    endfunction

    function automatic flags_t classify_point(input logic signed [VEL_W-1:0] vx,
                                              input logic signed [VEL_W-1:0] vy,
                                              input logic signed [PT_W-1:0]  px,
                                              input logic signed [PT_W-1:0]  py);
        flags_t          f;
        longint unsigned spd;
        longint unsigned a;
        longint          b;
        longint unsigned bmag;
        longint          sx;
        longint          sy;
        longint unsigned tx;
        longint unsigned ty;
        longint          cond;
        longint          tol;
        f    = '0;
        spd  = speed_of(vx, vy);
        a    = forward_axis(spd);
        b    = shoulder_axis(spd);
        if (a == 0 || b == 0) begin
            f.degenerate = 1'b1;
            return f;
        end
        bmag = (b < 0) ? -b : b;
        sx   = px;
        sy   = py;
        tx   = (longint'(sx * sx) << 16) / (a * a);
        ty   = (longint'(sy * sy) << 16) / (bmag * bmag);
        cond = longint'(tx + ty) - 65536;
        tol  = longint'(shadow_tol);
        f.inside_res  = cond < 0;
        f.outside     = cond > 0;
        f.on_boundary = (-tol < cond) && (cond < tol);
        return f;
    endfunction

    // All handshakes are observed at the rising edge. Accepted points get their
    // expectation here, and register writes update the shadow configuration.
    always @(posedge aclk) begin
        flags_t got;
        flags_t want;
        if (!aresetn) begin
            shadow_a_min       <= RST_A_MIN;
            shadow_a_per_speed <= RST_A_PER_SPD;
            shadow_b_min       <= RST_B_MIN;
            shadow_b_max       <= RST_B_MAX;
            shadow_v0          <= RST_V0;
            shadow_stretch     <= RST_STRETCH;
            shadow_tol         <= RST_TOL;
            quiet_cycles       <= 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (s_valid && s_ready)
                expected_flags.push_back(classify_point(s_vel_x, s_vel_y, s_point_x,
                                                        s_point_y));
            if (m_valid && m_ready) begin
                got = {m_inside_res, m_outside, m_on_boundary, m_degenerate};
                if (expected_flags.size() == 0) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= 10)
                        $display("unexpected result word %b", got);
                end else begin
                    want = expected_flags.pop_front();
                    if (got !== want) begin
                        mismatch_count = mismatch_count + 1;
                        if (mismatch_count <= 10)
                            $display("mismatch: expected in/out/on/deg %b, got %b",
                                     want, got);
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_reg_t'(cfg_addr))
                    REG_A_MIN:         shadow_a_min       <= cfg_wdata;
                    REG_A_PER_SPEED:   shadow_a_per_speed <= cfg_wdata;
                    REG_B_MIN:         shadow_b_min       <= cfg_wdata;
                    REG_B_MAX:         shadow_b_max       <= cfg_wdata;
                    REG_DESIRED_SPEED: shadow_v0          <= cfg_wdata;
                    REG_STRETCH:       shadow_stretch     <= cfg_wdata[0];
                    REG_TOLERANCE:     shadow_tol         <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // A long run of cycles with no handshake at all means the block has hung.
    always @(posedge aclk) begin
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // The receiver stalls in random bursts, or once for one long stretch on request.
    initial begin
        m_ready   = 1'b0;
        hold_done = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_len > 0 && !hold_done) begin
                m_ready <= 1'b0;
                repeat (hold_len - 1) @(negedge aclk);
                hold_done = 1'b1;
            end else if (receiver_idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Sends one word. Valid stays high between back-to-back words and drops only
    // for an idle burst or when the caller lowers it.
    task automatic send_point(input logic signed [VEL_W-1:0] vx,
                              input logic signed [VEL_W-1:0] vy,
                              input logic signed [PT_W-1:0]  px,
                              input logic signed [PT_W-1:0]  py);
        if (sender_idle_on && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_vel_x   <= vx;
        s_vel_y   <= vy;
        s_point_x <= px;
        s_point_y <= py;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic stop_sending();
        s_valid <= 1'b0;
        @(negedge aclk);
    endtask

    // Waits until every expected result has come back, then lets the pipeline settle.
    task automatic wait_drained();
        stop_sending();
        while (expected_flags.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic load_config(input logic [CFG_W-1:0] amin, input logic [CFG_W-1:0] av,
                               input logic [CFG_W-1:0] bmin, input logic [CFG_W-1:0] bmax,
                               input logic [CFG_W-1:0] v0, input logic stretch,
                               input logic [CFG_W-1:0] tol);
        wait_drained();
        write_reg(REG_A_MIN, amin);
        write_reg(REG_A_PER_SPEED, av);
        write_reg(REG_B_MIN, bmin);
        write_reg(REG_B_MAX, bmax);
        write_reg(REG_DESIRED_SPEED, v0);
        write_reg(REG_STRETCH, {15'd0, stretch});
        write_reg(REG_TOLERANCE, tol);
    endtask

    // A point scaled to the current ellipse, so that all three outcomes turn up.
    // Every few words the fields are fully random instead.
    task automatic send_random_point();
        logic signed [VEL_W-1:0] vx;
        logic signed [VEL_W-1:0] vy;
        longint unsigned         spd;
        longint                  ra;
        longint                  rb;
        longint                  px;
        longint                  py;
        if ($urandom_range(0, 3) == 0) begin
            send_point(VEL_W'($urandom), VEL_W'($urandom), PT_W'($urandom),
                       PT_W'($urandom));
        end else begin
            vx  = $signed(VEL_W'($urandom)) >>> $urandom_range(0, 15);
            vy  = $signed(VEL_W'($urandom)) >>> $urandom_range(0, 15);
            spd = speed_of(vx, vy);
            ra  = forward_axis(spd);
            rb  = shoulder_axis(spd);
            if (rb < 0) rb = -rb;
            ra  = (ra > 200000) ? 200000 : ra;
            rb  = (rb > 200000) ? 200000 : rb;
            px  = longint'($urandom_range(0, 32'(2 * ra + 2))) - ra - 1;
            py  = longint'($urandom_range(0, 32'(2 * rb + 2))) - rb - 1;
            if ($urandom_range(0, 2) == 0) py = 0;
            send_point(vx, vy, PT_W'(px), PT_W'(py));
        end
    endtask

    task automatic random_phase(input int count);
        repeat (count) send_random_point();
    endtask

    // Field extremes and hand-placed points under the reset configuration.
    task automatic test_extremes();
        send_point(16'sd0, 16'sd0, 20'sd0, 20'sd0);
        send_point(16'sd0, 16'sd0, 20'sd737, 20'sd0);
        send_point(16'sd0, 16'sd0, 20'sd0, 20'sd1024);
        send_point(16'sd0, 16'sd0, 20'sd738, 20'sd0);
        send_point(16'sd0, 16'sd0, 20'sd736, 20'sd0);
        send_point(-16'sd32768, -16'sd32768, -20'sd524288, -20'sd524288);
        send_point(16'sd32767, 16'sd32767, 20'sd524287, 20'sd524287);
        send_point(-16'sd32768, 16'sd32767, 20'sd524287, -20'sd524288);
        send_point(16'sd4096, 16'sd0, 20'sd0, -20'sd1);
    endtask

    // Both axes zero at once, and then a zero shoulder axis alone.
    task automatic test_degenerate();
        load_config(16'd0, 16'd0, 16'd0, 16'd1024, 16'd0, 1'b0, 16'd66);
        send_point(16'sd0, 16'sd0, 20'sd5, 20'sd5);
        send_point(16'sd100, 16'sd0, 20'sd5, 20'sd5);
        load_config(16'd500, 16'd100, 16'd0, 16'd1024, 16'd0, 1'b0, 16'd66);
        send_point(16'sd0, 16'sd0, 20'sd0, 20'sd0);
        send_point(16'sd32767, 16'sd0, 20'sd100, 20'sd0);
    endtask

    // A b_min above b_max makes the shoulder grow with speed; shrinking past zero gives a negative
    // shoulder axis, which still classifies; a desired speed at the floor code keeps the shoulder at its maximum.
    task automatic test_shoulder_shrink();
        load_config(16'd737, 16'd2171, 16'd4000, 16'd1000, 16'd4096, 1'b1, 16'd66);
        send_point(16'sd8192, 16'sd0, 20'sd100, 20'sd3000);
        send_point(-16'sd32768, 16'sd0, 20'sd100, 20'sd3000);
        load_config(16'd737, 16'd2171, 16'd100, 16'd2000, 16'd5, 1'b1, 16'd66);
        send_point(16'sd4096, 16'sd0, 20'sd0, 20'sd10);
        send_point(16'sd1, 16'sd0, 20'sd0, 20'sd2000);
        load_config(16'd737, 16'd2171, 16'd100, 16'd2000, 16'd4, 1'b1, 16'd66);
        send_point(16'sd4096, 16'sd0, 20'sd0, 20'sd2000);
    endtask

    // With no tolerance the boundary band is empty, even exactly on the ellipse.
    task automatic test_zero_tolerance();
        load_config(16'd737, 16'd0, 16'd819, 16'd1024, 16'd0, 1'b1, 16'd0);
        send_point(16'sd0, 16'sd0, 20'sd737, 20'sd0);
        send_point(16'sd0, 16'sd0, 20'sd0, 20'sd1024);
        random_phase(60);
    endtask

    // Random words under a spread of configurations, extremes among them.
    task automatic test_random_configs();
        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 16'hFFFF);
        random_phase(150);
        load_config(16'd1, 16'd1, 16'd1, 16'd1, 16'd0, 1'b0, 16'd1);
        random_phase(150);
        load_config(16'd737, 16'd2171, 16'd819, 16'd1024, 16'd5734, 1'b1, 16'd400);
        random_phase(200);
        repeat (4) begin
            load_config(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom),
                        CFG_W'($urandom),
                        ($urandom_range(0, 8) == 0) ? CFG_W'($urandom_range(0, 5))
                                                    : CFG_W'($urandom),
                        1'($urandom_range(0, 1)),
                        ($urandom_range(0, 1) != 0) ? CFG_W'($urandom) : 16'd2000);
            random_phase(120);
        end
    endtask

    // The receiver stops for a long stretch while words keep coming, so the pipeline
    // and its skid buffer fill and s_ready drops; then the sender waits for a full drain.
    task automatic test_full_pipeline();
        load_config(16'd737, 16'd2171, 16'd819, 16'd1024, 16'd6000, 1'b1, 16'd300);
        hold_len = 400;
        random_phase(200);
        wait_drained();
        random_phase(60);
    endtask

    // The last part runs with no idling on either side.
    task automatic test_streaming();
        sender_idle_on   = 1'b0;
        receiver_idle_on = 1'b0;
        random_phase(200);
    endtask

    initial begin
        hold_len         = 0;
        sender_idle_on   = 1'b1;
        receiver_idle_on = 1'b1;
        aresetn          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_addr         = '0;
        cfg_wdata        = '0;
        s_valid          = 1'b0;
        s_vel_x          = '0;
        s_vel_y          = '0;
        s_point_x        = '0;
        s_point_y        = '0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_extremes();
        test_degenerate();
        test_shoulder_shrink();
        test_zero_tolerance();
        test_random_configs();
        test_full_pipeline();
        test_streaming();

        wait_drained();
        if (mismatch_count == 0 && expected_flags.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/epc_pkg.sv
hw/rtl/epc_sqrt.sv
hw/rtl/epc_div.sv
hw/rtl/ellipse_point_classify.sv
hw/rtl/epc_checker.sv
tb/sv/testbench.sv
